>>> hdl/p7u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p7u_pkg
// shared types and constants for the pkcs#7 padding removal block
// ----------------------------------------------------------------------------
package p7u_pkg;

    localparam int MAX_BLOCK_DEF = 16;

    // block size register
    localparam int              BS_W     = 5;
    localparam logic [BS_W-1:0] BS_RESET = 5'd16;

    // end status codes
    localparam logic [1:0] CODE_OK       = 2'd0;
    localparam logic [1:0] CODE_LEN      = 2'd1;
    localparam logic [1:0] CODE_PAD_LEN  = 2'd2;
    localparam logic [1:0] CODE_PAD_BYTE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       status_item;
        logic [1:0] status_code;
        logic       run_last;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RELEASE,
        S_STATUS
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rot_step;
        logic rel_step;
        logic emit_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic in_final;
        logic rot_last;
        logic check_ok;
        logic keep_zero;
        logic rel_last;
    } dp_stat_t;

endpackage

>>> hdl/p7u_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p7u_datapath
// hold buffer, counters, pad check and output register
// ----------------------------------------------------------------------------
module p7u_datapath #(
    parameter int MAX_BLOCK = p7u_pkg::MAX_BLOCK_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [p7u_pkg::BS_W-1:0] cfg_wdata,
    input  p7u_pkg::in_item_t        s_data,
    input  logic                     m_ready,
    output logic                     m_valid,
    output p7u_pkg::out_item_t       m_data,
    input  p7u_pkg::dp_cmd_t         cmd,
    output p7u_pkg::dp_stat_t        stat
);
    import p7u_pkg::*;

    localparam int DEPTH = MAX_BLOCK + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_BLOCK + 2);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);
    localparam logic [CNT_W-1:0] ROT_END = CNT_W'(DEPTH - 1);

    logic [7:0]       hold_reg [DEPTH];
    logic [7:0]       hold_next [DEPTH];
    logic [BS_W-1:0]  bs_reg;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] cnt_reg, keep_reg;
    logic [7:0]       pad_reg;
    logic [1:0]       code_reg;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic [CNT_W-1:0] eff_bs;
    logic             rel_now;
    logic             shift_in;
    logic [CNT_W-1:0] wr_idx;
    logic [CNT_W-1:0] phase_inc;
    logic [CNT_W-1:0] cnt_in;
    logic [CNT_W-1:0] keep_in;
    logic [CNT_W-1:0] step_inc;
    logic [7:0]       pad_in;
    logic [1:0]       early_code;
    logic             mismatch;
    logic             out_free;
    logic             out_load;

    // block size clamped to 1..MAX_BLOCK
    always_comb begin
        if (bs_reg == '0) begin
            eff_bs = CNT_W'(1);
        end else if (8'(bs_reg) > 8'(MAX_BLOCK)) begin
            eff_bs = MAX_CNT;
        end else begin
            eff_bs = CNT_W'(bs_reg);
        end
    end

    assign rel_now   = (held_reg >= eff_bs) && (held_reg != '0);
    assign shift_in  = rel_now && !s_data.final_byte;
    assign wr_idx    = held_reg - CNT_W'(shift_in);
    assign phase_inc = phase_reg + CNT_W'(1);
    assign cnt_in    = held_reg + CNT_W'(1);
    assign pad_in    = s_data.data_byte;
    assign keep_in   = cnt_in - CNT_W'(pad_in);
    assign step_inc  = step_reg + CNT_W'(1);

    // length and pad range checks on the final byte
    always_comb begin
        if (phase_inc != eff_bs) begin
            early_code = CODE_LEN;
        end else if (pad_in == 8'd0 || pad_in > 8'(eff_bs) || pad_in > 8'(cnt_in)) begin
            early_code = CODE_PAD_LEN;
        end else begin
            early_code = CODE_OK;
        end
    end

    // pad byte compare while the buffer rotates past slot 0
    assign mismatch = cmd.rot_step && (step_reg >= keep_reg) && (step_reg < cnt_reg)
                      && (hold_reg[0] != pad_reg);

    always_comb begin
        hold_next = hold_reg;
        if (cmd.accept) begin
            if (shift_in) begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    hold_next[i] = hold_reg[i+1];
                end
            end
            hold_next[wr_idx[IDX_W-1:0]] = s_data.data_byte;
        end else if (cmd.rot_step) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                hold_next[i] = hold_reg[i+1];
            end
            hold_next[DEPTH-1] = hold_reg[0];
        end else if (cmd.rel_step) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                hold_next[i] = hold_reg[i+1];
            end
        end
    end

    always_comb begin
        held_next  = held_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        if (cmd.accept) begin
            if (s_data.final_byte) begin
                held_next  = '0;
                phase_next = '0;
                step_next  = '0;
            end else begin
                held_next  = wr_idx + CNT_W'(1);
                phase_next = (phase_inc >= eff_bs) ? '0 : phase_inc;
            end
        end else if (cmd.rot_step) begin
            step_next = (step_reg == ROT_END) ? '0 : step_inc;
        end else if (cmd.rel_step) begin
            step_next = step_inc;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (cmd.accept && shift_in) || cmd.rel_step || cmd.emit_status;

    always_comb begin
        m_data_next             = m_data_reg;
        m_data_next.out_byte    = hold_reg[0];
        m_data_next.status_item = 1'b0;
        m_data_next.status_code = CODE_OK;
        m_data_next.run_last    = cmd.accept;
        if (cmd.emit_status) begin
            m_data_next.out_byte    = 8'd0;
            m_data_next.status_item = 1'b1;
            m_data_next.status_code = code_reg;
            m_data_next.run_last    = 1'b1;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg      <= BS_RESET;
            held_reg    <= '0;
            phase_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                bs_reg <= cfg_wdata;
            end
            held_reg    <= held_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
        if (cmd.accept && s_data.final_byte) begin
            cnt_reg  <= cnt_in;
            keep_reg <= keep_in;
            pad_reg  <= pad_in;
            code_reg <= early_code;
        end else if (mismatch && code_reg == CODE_OK) begin
            code_reg <= CODE_PAD_BYTE;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.out_free  = out_free;
    assign stat.in_final  = s_data.final_byte;
    assign stat.rot_last  = (step_reg == ROT_END);
    assign stat.check_ok  = (code_reg == CODE_OK) && !mismatch;
    assign stat.keep_zero = (keep_reg == '0);
    assign stat.rel_last  = (step_inc == keep_reg);

endmodule

>>> hdl/p7u_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p7u_ctrl
// sequencer for byte intake and the end-of-message check and flush
// ----------------------------------------------------------------------------
module p7u_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output p7u_pkg::dp_cmd_t  cmd,
    input  p7u_pkg::dp_stat_t stat
);
    import p7u_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = stat.out_free;
                cmd.accept = s_valid && stat.out_free;
                if (cmd.accept && stat.in_final) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.rot_step = 1'b1;
                if (stat.rot_last) begin
                    state_next = (stat.check_ok && !stat.keep_zero) ? S_RELEASE : S_STATUS;
                end
            end
            S_RELEASE: begin
                if (stat.out_free) begin
                    cmd.rel_step = 1'b1;
                    if (stat.rel_last) begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_STATUS: begin
                if (stat.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/pkcs7_unpad_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7_unpad_checker_top
// pkcs#7 padding removal and check on a byte stream
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one message byte per transfer, final_byte set on the last one.
//   m_ channel: released bytes (status_item 0) and one end status item per
//   message (status_item 1, status_code 0 ok, else the failure reason).
//   cfg_we/cfg_wdata write the block length; write it only while idle.
// intake and flush
//   a non-final byte is written into the hold buffer; the byte it pushes out
//   of the hold buffer is presented on m_ the next cycle, and the next byte is
//   taken at once as long as the output register is empty or being drained.
//   a final byte starts a flush: the hold buffer rotates through the pad
//   compare at slot 0, then the kept bytes are released if the check passed,
//   then the status item goes out; s_ready stays low meanwhile.
// reset and stall
//   reset empties the hold buffer count, clears the phase, sets the block
//   length to 16 and drops m_valid. a stalled m_ready holds the output
//   register and s_ready falls until it drains; nothing is lost or repeated.
//   on an error status, bytes released earlier must be dropped downstream.
// ----------------------------------------------------------------------------
module pkcs7_unpad_checker_top #(
    parameter int MAX_BLOCK = p7u_pkg::MAX_BLOCK_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [p7u_pkg::BS_W-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  p7u_pkg::in_item_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output p7u_pkg::out_item_t       m_data
);
    import p7u_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: intake, rotate for the pad compare, release, status
    p7u_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // datapath: hold buffer, phase and count, checks, output register
    p7u_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef SYNTHESIS
    // an input transfer never lands on a pending result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken while output register is blocked");

    // a final byte closes intake until the flush is over
    a_flush_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.final_byte) |=> !s_ready)
        else $error("input taken right after a final byte");

    // the status item always ends its run
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status_item) |-> m_data.run_last)
        else $error("status item without run_last");

    // byte items carry no error code
    a_byte_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.status_item) |-> (m_data.status_code == CODE_OK))
        else $error("byte item with nonzero status code");
`endif

endmodule

>>> verif/tb_pkcs7_unpad_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pkcs7_unpad_checker_top
// self-checking bench for the pkcs#7 padding removal block: a queue-fed
// driver pushes padded messages over s_, a clocked monitor predicts every
// released byte and end status and compares each m_ transfer field by field
// ----------------------------------------------------------------------------
module tb_pkcs7_unpad_checker_top;
    import p7u_pkg::*;

    localparam int MAX_BLOCK   = MAX_BLOCK_DEF;
    // idle wait after the last result, sized from MAX_BLOCK with some margin
    localparam int FLUSH_GAP   = MAX_BLOCK + 8;
    localparam int CYCLE_LIMIT = 400000;
    // minimum random byte transfers queued per pacing phase
    localparam int PHASE_ITEMS = 22;
    // block sizes that open each pacing phase: both ends and both out of range
    localparam logic [BS_W-1:0] EDGE_SIZES [4] = '{5'd1, 5'd16, 5'd0, 5'd31};

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [BS_W-1:0] cfg_wdata = '0;
    logic            s_valid   = 1'b0;
    logic            s_ready;
    in_item_t        s_data    = '0;
    logic            m_valid;
    logic            m_ready   = 1'b0;
    out_item_t       m_data;

    // byte transfers waiting for the driver, and results waiting for the dut
    in_item_t        pending_in [$];
    out_item_t       expected_out [$];
    out_item_t       want_item;

    // predictor state: held bytes oldest first, fill level, length phase
    logic [7:0]      held_bytes [MAX_BLOCK];
    int unsigned     held_n       = 0;
    int unsigned     msg_phase    = 0;
    logic [BS_W-1:0] blk_size_reg = BS_RESET;
    // last value written, as seen by the stimulus side
    logic [BS_W-1:0] cfg_shadow   = BS_RESET;

    // handshake pacing, percent of cycles
    int unsigned     send_idle_pct = 0;
    int unsigned     rcv_stall_pct = 0;

    logic            in_acc = 1'b0;
    int unsigned     queued_n    = 0;
    int unsigned     sent_n      = 0;
    int unsigned     out_xfers   = 0;
    int unsigned     cfg_writes  = 0;
    int unsigned     cycle_n     = 0;
    int unsigned     err_n       = 0;
    int unsigned     status_seen [4] = '{0, 0, 0, 0};

    always #2 aclk = ~aclk;

    pkcs7_unpad_checker_top #(
        .MAX_BLOCK (MAX_BLOCK)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // out-of-range sizes clamp: zero acts as one, above MAX_BLOCK as MAX_BLOCK
    function automatic int unsigned eff_blk(logic [BS_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_BLOCK) return MAX_BLOCK;
        return 32'(v);
    endfunction

    function automatic void add_result(logic [7:0] b, logic st, logic [1:0] code,
                                       logic last);
        expected_out.insert(expected_out.size(), out_item_t'{b, st, code, last});
    endfunction

    // expected results of one accepted byte transfer
    function automatic void unpad_step(in_item_t it);
        int unsigned bs;
        int unsigned nxt;
        int unsigned cnt;
        int unsigned pad;
        logic [1:0]  code;
        logic [7:0]  seq [MAX_BLOCK + 1];
        bs  = eff_blk(blk_size_reg);
        nxt = msg_phase + 1;
        if (!it.final_byte) begin
            // the oldest held byte falls out once a whole block is held
            if (held_n >= bs && held_n > 0) begin
                add_result(held_bytes[0], 1'b0, CODE_OK, 1'b1);
                for (int i = 0; i + 1 < held_n; i++) held_bytes[i] = held_bytes[i + 1];
                held_n--;
            end
            if (held_n < MAX_BLOCK) begin
                held_bytes[held_n] = it.data_byte;
                held_n++;
            end
            // a stale phase above a smaller new size still wraps here
            msg_phase = (nxt >= bs) ? 0 : nxt;
        end else begin
            for (int i = 0; i < held_n; i++) seq[i] = held_bytes[i];
            seq[held_n] = it.data_byte;
            cnt  = held_n + 1;
            pad  = 32'(it.data_byte);
            code = CODE_OK;
            // checks in priority order: length, pad length, pad contents
            if (nxt != bs) begin
                code = CODE_LEN;
            end else if (pad == 0 || pad > bs || pad > cnt) begin
                code = CODE_PAD_LEN;
            end else begin
                for (int i = 0; i < pad; i++) begin
                    if (seq[cnt - 1 - i] != it.data_byte) code = CODE_PAD_BYTE;
                end
            end
            if (code == CODE_OK) begin
                for (int i = 0; i < cnt - pad; i++) add_result(seq[i], 1'b0, CODE_OK, 1'b0);
            end
            add_result(8'h00, 1'b1, code, 1'b1);
            // next byte always opens a new message
            held_n    = 0;
            msg_phase = 0;
        end
    endfunction

    task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            err_n++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the next byte at the falling edge once the last one moved,
    // and redraws the receiver stall every cycle
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_valid || in_acc) begin
            if (pending_in.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_in.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: checks result transfers, then feeds the predictor with the
    // input transfer of the same edge (its results can only come later)
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_n, expected_out.size());
            $display("DONE: errors detected");
            $finish;
        end else if (aresetn) begin
            in_acc <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                out_xfers++;
                if (expected_out.size() == 0) begin
                    $error("unexpected result: out_byte %0d status_item %0d code %0d last %0d",
                           m_data.out_byte, m_data.status_item, m_data.status_code,
                           m_data.run_last);
                    err_n++;
                end else begin
                    want_item = expected_out.pop_front();
                    check_field("out_byte", want_item.out_byte, m_data.out_byte);
                    check_field("status_item", 8'(want_item.status_item),
                                8'(m_data.status_item));
                    check_field("status_code", 8'(want_item.status_code),
                                8'(m_data.status_code));
                    check_field("run_last", 8'(want_item.run_last), 8'(m_data.run_last));
                    if (want_item.status_item) status_seen[want_item.status_code]++;
                end
            end
            // writes only happen while no byte is in flight
            if (cfg_we) blk_size_reg = cfg_wdata;
            if (s_valid && s_ready) begin
                unpad_step(s_data);
                sent_n++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers; queue pushes happen on the rising edge so the driver
    // never races the producer
    // ------------------------------------------------------------------------
    task automatic send_bytes(logic [7:0] bytes [$], logic ends);
        in_item_t it;
        @(posedge aclk);
        foreach (bytes[i]) begin
            it.data_byte  = bytes[i];
            it.final_byte = ends && (i == bytes.size() - 1);
            pending_in.insert(pending_in.size(), it);
            queued_n++;
        end
    endtask

    // block idle: every byte taken, every result seen, flush given time to end
    task automatic settle();
        @(negedge aclk);
        while (sent_n != queued_n || expected_out.size() != 0) @(negedge aclk);
        repeat (FLUSH_GAP) @(negedge aclk);
    endtask

    // call from a falling edge with the block idle
    task automatic write_blk_size(logic [BS_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cfg_shadow = v;
        cfg_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-padded messages with random content, some broken ones
    task automatic queue_msg();
        logic [7:0]  msg [$];
        logic [7:0]  head [$];
        logic [7:0]  tail [$];
        int unsigned bs;
        int unsigned kind;
        int unsigned pad;
        int unsigned len;
        int unsigned split;
        bs   = eff_blk(cfg_shadow);
        kind = $urandom_range(0, 9);
        pad  = $urandom_range(1, bs);
        len  = bs * $urandom_range(1, (bs > 8) ? 2 : 3);
        repeat (len - pad) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        repeat (pad) msg.insert(msg.size(), 8'(pad));
        case (kind)
            6: begin
                // length off by one byte
                if (msg.size() > 1 && $urandom_range(0, 1) == 1) begin
                    void'(msg.pop_front());
                end else begin
                    msg.push_front(8'($urandom_range(0, 255)));
                end
            end
            7: begin
                // one corrupted pad byte, or a pad length one too big
                if (pad > 1) begin
                    msg[len - 1 - $urandom_range(1, pad - 1)] ^= 8'(1 << $urandom_range(0, 7));
                end else begin
                    msg[len - 1] = 8'(pad + 1);
                end
            end
            8: begin
                // pad length zero or above the block size
                msg[len - 1] = ($urandom_range(0, 1) == 1) ? 8'h00
                                                           : 8'($urandom_range(bs + 1, 255));
            end
            default: ;
        endcase
        if (kind == 9 && msg.size() > 1) begin
            // block size changed partway through the message
            split = $urandom_range(1, msg.size() - 1);
            foreach (msg[i]) begin
                if (i < split) begin
                    head.insert(head.size(), msg[i]);
                end else begin
                    tail.insert(tail.size(), msg[i]);
                end
            end
            send_bytes(head, 1'b0);
            settle();
            write_blk_size(BS_W'($urandom_range(0, 31)));
            send_bytes(tail, 1'b1);
        end else begin
            send_bytes(msg, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]      msg [$];
        logic [BS_W-1:0] pick;
        int unsigned     start_n;
        logic            first_pick;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset size is 16, so a two-byte message fails on length
        msg = {8'h5A, 8'h01};
        send_bytes(msg, 1'b1);
        settle();
        write_blk_size(5'd4);
        // good padding with byte extremes in the body
        msg = {8'h00, 8'hFF, 8'h02, 8'h02};
        send_bytes(msg, 1'b1);
        // short message
        msg = {8'h11, 8'h04};
        send_bytes(msg, 1'b1);
        // pad length zero
        msg = {8'h12, 8'h34, 8'h56, 8'h00};
        send_bytes(msg, 1'b1);
        // pad length above the block size
        msg = {8'h12, 8'h34, 8'h56, 8'h05};
        send_bytes(msg, 1'b1);
        // pad bytes disagree
        msg = {8'hAB, 8'h02, 8'h03, 8'h03};
        send_bytes(msg, 1'b1);
        // whole block is padding, only the status comes out
        msg = {8'h04, 8'h04, 8'h04, 8'h04};
        send_bytes(msg, 1'b1);

        // pacing phases: none, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            @(posedge aclk);
            send_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 33 : 0;
            rcv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 33 : 0;
            start_n    = queued_n;
            first_pick = 1'b1;
            while (queued_n - start_n < PHASE_ITEMS) begin
                settle();
                if (first_pick) begin
                    pick = EDGE_SIZES[ph];
                end else if ($urandom_range(0, 9) < 7) begin
                    pick = BS_W'($urandom_range(1, 8));
                end else begin
                    pick = BS_W'($urandom_range(0, 31));
                end
                first_pick = 1'b0;
                write_blk_size(pick);
                repeat ($urandom_range(1, 3)) queue_msg();
            end
        end

        settle();
        $display("%0d byte transfers in, %0d results out, %0d block size writes, %0d cycles",
                 sent_n, out_xfers, cfg_writes, cycle_n);
        $display("end status seen: ok %0d, length %0d, pad length %0d, pad byte %0d",
                 status_seen[CODE_OK], status_seen[CODE_LEN], status_seen[CODE_PAD_LEN],
                 status_seen[CODE_PAD_BYTE]);
        if (err_n == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
